/* src/ptb_pkg.sv */
// ptb_pkg: widths, codes, entry layout and defaults of the endpoint token bucket
// no dependencies; imported by ptb_div and per_endpoint_token_bucket

package ptb_pkg;

    localparam int PTB_NUM_ENDPOINTS = 64;

    localparam int TOKEN_W = 36;
    localparam int CAP_W   = 16;
    localparam int RATE_W  = 16;
    localparam int TIME_W  = 32;
    localparam int TPS_W   = 20;
    localparam int EP_W    = 6;
    localparam int WAIT_W  = 16;
    localparam int PROD_W  = TIME_W + RATE_W;
    localparam int LEVEL_W = PROD_W + 1;
    localparam int NEED_W  = 30;
    localparam int DEN_W   = RATE_W + TPS_W;
    localparam int QUOT_BITS = 10;
    localparam int DSR_W   = DEN_W + QUOT_BITS - 1;
    localparam int CNT_W   = 4;

    localparam logic [NEED_W-1:0] MS_PER_S = NEED_W'(1000);
    localparam logic [WAIT_W-1:0] WAIT_MAX = 16'hFFFF;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TPS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd2;

    localparam logic [RATE_W-1:0] RST_DEFAULT_RATE     = 16'd10;
    localparam logic [CAP_W-1:0]  RST_DEFAULT_CAPACITY = 16'd10;
    localparam logic [TPS_W-1:0]  RST_TICKS_PER_SECOND = 20'd1000000;

    localparam logic [1:0] REQ_ALLOW = 2'd0;
    localparam logic [1:0] REQ_WAIT  = 2'd1;
    localparam logic [1:0] REQ_SET   = 2'd2;
    localparam logic [1:0] REQ_RESET = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [TOKEN_W-1:0] tokens;
        logic [CAP_W-1:0]   cap;
        logic [RATE_W-1:0]  rate;
        logic [TIME_W-1:0]  last_time;
    } entry_t;

    localparam int ENTRY_W = 1 + TOKEN_W + CAP_W + RATE_W + TIME_W;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* src/ptb_if.sv */
// ptb_req_if / ptb_rsp_if: valid-ready channels for request and response words
// no dependencies

interface ptb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [5:0]  endpoint;
    logic [31:0] now_ticks;
    logic [15:0] rate;
    logic [15:0] capacity;

    modport source (output valid, req_type, endpoint, now_ticks, rate, capacity,
                    input ready);
    modport sink   (input valid, req_type, endpoint, now_ticks, rate, capacity,
                    output ready);
endinterface

interface ptb_rsp_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic [15:0] wait_ms;

    modport source (output valid, allowed, wait_ms, input ready);
    modport sink   (input valid, allowed, wait_ms, output ready);
endinterface

/* src/ptb_ram.sv */
// ptb_ram: generic single-write, single-read memory with registered read data
// no dependencies

module ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/ptb_div.sv */
// ptb_div: restoring divider, one quotient bit per cycle, for the wait query
// depends on ptb_pkg

module ptb_div
    import ptb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NEED_W-1:0]    need,
    input  logic [DEN_W-1:0]     den,
    output div_stat_t            stat,
    output logic [QUOT_BITS-1:0] quotient
);

    logic [NEED_W-1:0]    rem_reg, rem_next;
    logic [DSR_W-1:0]     dsr_reg, dsr_next;
    logic [QUOT_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic                 busy;
    logic                 fits;

    assign busy = (cnt_reg != '0);
    assign fits = ({{(DSR_W-NEED_W){1'b0}}, rem_reg} >= dsr_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = need;
            dsr_next = {den, {(QUOT_BITS-1){1'b0}}};
            quo_next = '0;
            cnt_next = CNT_W'(QUOT_BITS);
        end
        else if (busy)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsr_reg[NEED_W-1:0];
            end
            quo_next  = {quo_reg[QUOT_BITS-2:0], fits};
            dsr_next  = dsr_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

/* src/per_endpoint_token_bucket.sv */
// per_endpoint_token_bucket: table of token buckets kept in one memory, read-modify-write
// depends on ptb_pkg, ptb_if, ptb_ram, ptb_div
//
//   port   dir  words                                        accepted when
//   req    in   req_type, endpoint, now_ticks, rate, capacity valid && ready
//   rsp    out  allowed, wait_ms                             valid && ready
//   cfg_*  in   cfg_index, cfg_data                          cfg_we
//
// allow, set limit, quick wait query: S_RD, S_MUL, S_UPD, then the response word is registered
// wait query through the divider: S_RD, S_MUL, S_UPD, S_DIVP, then 10 divider steps in S_DIV
// reset all: one read per entry, written back only where the entry is valid
// after reset, a clearing pass writes zero to every entry before req.ready rises
// one request in flight; a stalled rsp holds its word while the next request is taken

module per_endpoint_token_bucket
    import ptb_pkg::*;
#(
    parameter int NUM_ENDPOINTS = PTB_NUM_ENDPOINTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ptb_req_if.sink               req,
    ptb_rsp_if.source             rsp
);

    localparam int AW = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ENDPOINTS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_DIVP  = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      addr_reg, addr_next;

    logic [RATE_W-1:0]  def_rate_reg;
    logic [CAP_W-1:0]   def_cap_reg;
    logic [TPS_W-1:0]   tps_reg;

    logic [1:0]         kind_reg;
    logic               inrange_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [RATE_W-1:0]  rt_in_reg;
    logic [CAP_W-1:0]   cap_in_reg;

    entry_t             entry_reg;
    logic [TOKEN_W-1:0] full_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TPS_W-1:0]   lvl_reg;

    logic               res_allowed_reg, res_allowed_next;
    logic [WAIT_W-1:0]  res_wait_reg, res_wait_next;
    logic               rsp_valid_reg;
    logic               rsp_allowed_reg;
    logic [WAIT_W-1:0]  rsp_wait_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;
    entry_t             wr_entry;

    logic               accept;
    logic               out_free;
    logic               rsp_load;
    logic               fin;
    logic               fin_allowed;
    logic [WAIT_W-1:0]  fin_wait;

    logic [CAP_W-1:0]   cap_sel;
    logic [TOKEN_W-1:0] mul_full;
    logic [TIME_W-1:0]  elapsed;
    logic [PROD_W-1:0]  mul_prod;
    logic [TOKEN_W-1:0] base_tok;
    logic [LEVEL_W-1:0] level;
    logic [TOKEN_W-1:0] lvl;
    logic [TOKEN_W-1:0] tps_tok;
    logic               can_spend;
    logic [TOKEN_W-1:0] clip_tok;
    logic [TPS_W-1:0]   gap;
    logic [NEED_W-1:0]  need;
    logic [DEN_W-1:0]   den;
    logic               div_start;
    div_stat_t          div_stat;
    logic [QUOT_BITS-1:0] quotient;

    ptb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ENDPOINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .need     (need),
        .den      (den),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign rd_entry = entry_t'(ram_rdata);

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    // arithmetic of one entry
    assign cap_sel  = (kind_reg == REQ_SET) ? cap_in_reg :
                      ((kind_reg == REQ_ALLOW) && !rd_entry.valid) ? def_cap_reg :
                      rd_entry.cap;
    assign mul_full = TOKEN_W'(cap_sel) * TOKEN_W'(tps_reg);
    assign elapsed  = now_reg - entry_reg.last_time;
    assign mul_prod = PROD_W'(elapsed) * PROD_W'(entry_reg.rate);
    assign base_tok = entry_reg.valid ? entry_reg.tokens : full_reg;
    assign level    = LEVEL_W'(base_tok) + (entry_reg.valid ? LEVEL_W'(prod_reg) : '0);
    assign lvl      = (level > LEVEL_W'(full_reg)) ? full_reg : level[TOKEN_W-1:0];
    assign tps_tok  = TOKEN_W'(tps_reg);
    assign can_spend = (lvl >= tps_tok);
    assign clip_tok = (entry_reg.tokens > full_reg) ? full_reg : entry_reg.tokens;
    assign gap      = tps_reg - lvl_reg;
    assign need     = NEED_W'(gap) * MS_PER_S;
    assign den      = DEN_W'(entry_reg.rate) * DEN_W'(tps_reg);

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        ram_we           = 1'b0;
        ram_raddr        = addr_reg;
        wr_entry         = entry_reg;
        div_start        = 1'b0;
        fin              = 1'b0;
        fin_allowed      = 1'b0;
        fin_wait         = '0;
        rsp_load         = 1'b0;
        res_allowed_next = res_allowed_reg;
        res_wait_next    = res_wait_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                wr_entry = '0;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                ram_raddr = (req.req_type == REQ_RESET) ? '0 : AW'(req.endpoint);
                if (req.valid)
                begin
                    addr_next  = ram_raddr;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                case (kind_reg)
                    REQ_ALLOW:
                    begin
                        ram_we             = inrange_reg;
                        wr_entry.valid     = 1'b1;
                        wr_entry.tokens    = can_spend ? (lvl - tps_tok) : lvl;
                        wr_entry.cap       = entry_reg.valid ? entry_reg.cap : def_cap_reg;
                        wr_entry.rate      = entry_reg.valid ? entry_reg.rate : def_rate_reg;
                        wr_entry.last_time = now_reg;
                        fin                = 1'b1;
                        fin_allowed        = inrange_reg && can_spend;
                    end
                    REQ_WAIT:
                    begin
                        ram_we             = inrange_reg && entry_reg.valid;
                        wr_entry.tokens    = lvl;
                        wr_entry.last_time = now_reg;
                        if (!inrange_reg || !entry_reg.valid || can_spend)
                        begin
                            fin = 1'b1;
                        end
                        else if (entry_reg.rate == '0)
                        begin
                            fin      = 1'b1;
                            fin_wait = WAIT_MAX;
                        end
                        else
                        begin
                            state_next = S_DIVP;
                        end
                    end
                    REQ_SET:
                    begin
                        ram_we         = inrange_reg;
                        wr_entry.valid = 1'b1;
                        wr_entry.cap   = cap_in_reg;
                        wr_entry.rate  = rt_in_reg;
                        if (entry_reg.valid)
                        begin
                            wr_entry.tokens = clip_tok;
                        end
                        else
                        begin
                            wr_entry.tokens    = full_reg;
                            wr_entry.last_time = now_reg;
                        end
                        fin = 1'b1;
                    end
                    REQ_RESET:
                    begin
                        ram_we             = entry_reg.valid;
                        wr_entry.tokens    = full_reg;
                        wr_entry.last_time = now_reg;
                        if (addr_reg == LAST_ADDR)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            addr_next  = addr_reg + 1'b1;
                            ram_raddr  = addr_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                endcase
            end
            S_DIVP:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    fin      = 1'b1;
                    fin_wait = WAIT_W'(quotient);
                end
            end
            S_DONE:
            begin
                fin         = 1'b1;
                fin_allowed = res_allowed_reg;
                fin_wait    = res_wait_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                rsp_load   = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                res_allowed_next = fin_allowed;
                res_wait_next    = fin_wait;
                state_next       = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            def_rate_reg  <= RST_DEFAULT_RATE;
            def_cap_reg   <= RST_DEFAULT_CAPACITY;
            tps_reg       <= RST_TICKS_PER_SECOND;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEFAULT_RATE:     def_rate_reg <= cfg_data[RATE_W-1:0];
                    CFG_DEFAULT_CAPACITY: def_cap_reg  <= cfg_data[CAP_W-1:0];
                    CFG_TICKS_PER_SECOND: tps_reg      <= cfg_data[TPS_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= req.req_type;
            inrange_reg <= ({26'd0, req.endpoint} < 32'(NUM_ENDPOINTS));
            now_reg     <= req.now_ticks;
            rt_in_reg   <= req.rate;
            cap_in_reg  <= req.capacity;
        end
        if (state_reg == S_RD)
        begin
            entry_reg <= rd_entry;
            full_reg  <= mul_full;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= mul_prod;
        end
        if (state_reg == S_UPD)
        begin
            lvl_reg <= lvl[TPS_W-1:0];
        end
        if (rsp_load)
        begin
            rsp_allowed_reg <= fin_allowed;
            rsp_wait_reg    <= fin_wait;
        end
        res_allowed_reg <= res_allowed_next;
        res_wait_reg    <= res_wait_next;
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.allowed = rsp_allowed_reg;
    assign rsp.wait_ms = rsp_wait_reg;

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_RD))
        else $error("accepted word did not start a bucket read");

    a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> ($past(state_reg) == S_IDLE || $past(state_reg) == S_UPD))
        else $error("bucket read without a request or sweep step");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished with no wait query pending");

endmodule
